// ===== rtl/rdp_pkg.sv =====
`timescale 1ns / 1ps
package rdp_pkg;

   localparam int VALUE_BITS_DEF = 31;
   localparam int RADIX_BITS     = 8;
   localparam int RESULT_BITS    = 64;
   localparam int STATUS_BITS    = 2;
   // digit (radix-wide) times a 64-bit power of ten
   localparam int PROD_BITS      = RESULT_BITS + RADIX_BITS;

   typedef enum logic [STATUS_BITS-1:0] {
      RDP_ST_OK       = 2'd0,
      RDP_ST_BASE_ONE = 2'd1,
      RDP_ST_OVERFLOW = 2'd2
   } rdp_status_type;

   typedef enum logic [2:0] {
      RDP_OP_NONE,
      RDP_OP_LOAD,
      RDP_OP_PASS,
      RDP_OP_BASE1,
      RDP_OP_STEP,
      RDP_OP_MUL,
      RDP_OP_ACC,
      RDP_OP_EMIT
   } rdp_op_type;

   typedef struct packed {
      logic n_zero;
      logic r_zero;
      logic r_one;
      logic div_last;
      logic acc_ovf;
   } rdp_stat_type;

endpackage

// ===== rtl/rdp_dpath.sv =====
`timescale 1ns / 1ps
module rdp_dpath
   import rdp_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rdp_op_type             cmd,
   input  logic [VALUE_BITS-1:0]  number,
   input  logic [RADIX_BITS-1:0]  radix,
   output rdp_stat_type           stat,
   output logic [RESULT_BITS-1:0] out_value,
   output logic [STATUS_BITS-1:0] out_status
);

   localparam int CNT_BITS = $clog2(VALUE_BITS);
   localparam int P10_BITS = RESULT_BITS + 4;

   logic [VALUE_BITS-1:0]  n_ff;
   logic [RADIX_BITS-1:0]  r_ff;
   logic [RADIX_BITS-1:0]  rem_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic [RESULT_BITS-1:0] pow10_ff;
   logic                   pow_big_ff;
   logic [PROD_BITS-1:0]   prod_ff;
   logic                   mul_ovf_ff;
   logic [RESULT_BITS-1:0] sum_ff;
   rdp_status_type         status_ff;
   logic [RESULT_BITS-1:0] out_value_ff;
   rdp_status_type         out_status_ff;

   logic [RADIX_BITS:0]    trial;
   logic                   trial_ge;
   logic [RADIX_BITS:0]    trial_sub;
   logic [RADIX_BITS-1:0]  rem_in;
   logic [PROD_BITS-1:0]   prod_in;
   logic [PROD_BITS:0]     acc_sum;
   logic                   acc_ovf;
   logic [P10_BITS-1:0]    pow10_x;

   // one restoring division step: bring in the next dividend bit
   assign trial     = {rem_ff, n_ff[VALUE_BITS-1]};
   assign trial_ge  = trial >= {1'b0, r_ff};
   assign trial_sub = trial - {1'b0, r_ff};
   assign rem_in    = trial_ge ? trial_sub[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];

   assign prod_in = PROD_BITS'(rem_ff) * PROD_BITS'(pow10_ff);
   assign acc_sum = (PROD_BITS+1)'(sum_ff) + (PROD_BITS+1)'(prod_ff);
   assign acc_ovf = mul_ovf_ff || (acc_sum[PROD_BITS:RESULT_BITS] != '0);
   assign pow10_x = (P10_BITS'(pow10_ff) << 3) + (P10_BITS'(pow10_ff) << 1);

   always_ff @(posedge clock) begin
      unique case (cmd)
         RDP_OP_LOAD: begin
            n_ff       <= number;
            r_ff       <= radix;
            rem_ff     <= '0;
            cnt_ff     <= '0;
            pow10_ff   <= RESULT_BITS'(1);
            pow_big_ff <= 1'b0;
            sum_ff     <= '0;
            status_ff  <= RDP_ST_OK;
         end
         RDP_OP_PASS: begin
            sum_ff    <= RESULT_BITS'(n_ff);
            status_ff <= RDP_ST_OK;
         end
         RDP_OP_BASE1: begin
            sum_ff    <= '0;
            status_ff <= RDP_ST_BASE_ONE;
         end
         RDP_OP_STEP: begin
            n_ff   <= {n_ff[VALUE_BITS-2:0], trial_ge};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
         end
         RDP_OP_MUL: begin
            prod_ff    <= prod_in;
            mul_ovf_ff <= pow_big_ff && (rem_ff != '0);
         end
         RDP_OP_ACC: begin
            rem_ff <= '0;
            cnt_ff <= '0;
            if (acc_ovf) begin
               sum_ff    <= '0;
               status_ff <= RDP_ST_OVERFLOW;
            end else begin
               sum_ff <= acc_sum[RESULT_BITS-1:0];
            end
            // once ten to the next power no longer fits, freeze and flag it
            if (!pow_big_ff) begin
               if (pow10_x[P10_BITS-1:RESULT_BITS] != '0) begin
                  pow_big_ff <= 1'b1;
               end else begin
                  pow10_ff <= pow10_x[RESULT_BITS-1:0];
               end
            end
         end
         RDP_OP_EMIT: begin
            out_value_ff  <= sum_ff;
            out_status_ff <= status_ff;
         end
         default: begin
         end
      endcase
   end

   assign stat.n_zero   = (n_ff == '0);
   assign stat.r_zero   = (r_ff == '0);
   assign stat.r_one    = (r_ff == RADIX_BITS'(1));
   assign stat.div_last = (cnt_ff == CNT_BITS'(VALUE_BITS - 1));
   assign stat.acc_ovf  = acc_ovf;

   assign out_value  = out_value_ff;
   assign out_status = out_status_ff;

`ifndef SYNTHESIS
   a_ovf_clears_sum: assert property (@(posedge clock) disable iff (reset)
      (cmd == RDP_OP_ACC && acc_ovf) |=> (status_ff == RDP_ST_OVERFLOW && sum_ff == '0))
      else $error("overflow did not clear the running sum");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (cmd == RDP_OP_STEP) |=> (rem_ff < r_ff))
      else $error("partial remainder not below radix");
`endif

endmodule

// ===== rtl/rdp_ctrl.sv =====
`timescale 1ns / 1ps
module rdp_ctrl
   import rdp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  rdp_stat_type stat,
   output rdp_op_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      out_valid_ff;
   logic      out_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = RDP_OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd      = RDP_OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (stat.n_zero || stat.r_zero) begin
               cmd      = RDP_OP_PASS;
               state_in = ST_DONE;
            end else if (stat.r_one) begin
               cmd      = RDP_OP_BASE1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd = RDP_OP_STEP;
            if (stat.div_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd      = RDP_OP_MUL;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd = RDP_OP_ACC;
            // overflow or a quotient of zero ends the conversion
            if (stat.acc_ovf || stat.n_zero) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!out_valid_ff || rsp_tready) begin
               cmd      = RDP_OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      priority if (cmd == RDP_OP_EMIT) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

`ifndef SYNTHESIS
   a_accept_checks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CHECK))
      else $error("accepted transaction not followed by operand check");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      (cmd == RDP_OP_EMIT) |-> (!out_valid_ff || rsp_tready))
      else $error("result overwrote an untaken transaction");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !stat.div_last) |=> (state_ff == ST_DIV))
      else $error("division left before its last step");
`endif

endmodule

// ===== rtl/radix_digit_packer_core.sv =====
`timescale 1ns / 1ps
// Radix digit packer: converts a number to base radix and returns its digits
// weighted by successive powers of ten, so the base-radix form reads as decimal.
//   req channel : tdata = {radix, number}, one transaction per conversion.
//   rsp channel : tdata = packed value, tuser = status (ok, base one, overflow).
// A radix of zero or a number of zero returns the number unchanged; radix one
// returns status base one; a sum beyond 64 bits returns zero with overflow.
// A request is loaded, its operands are checked, and the special cases go
// straight to the output register. Otherwise each base-radix digit costs one
// restoring division of VALUE_BITS single-bit steps, a multiply by the current
// power of ten and an accumulate. An overflow ends the conversion at the digit
// that overflows. Radix two gives at most 31 digits. One conversion runs at a
// time; req_tready is high only while the engine is idle.
// The result sits in an output register, so a new request is taken while a
// response is still stalled; a finished conversion then waits for that slot.
// Synchronous reset returns to idle and drops any pending response.
module radix_digit_packer_core
   import rdp_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // number [VALUE_BITS-1:0], radix [VALUE_BITS+7:VALUE_BITS], zero pad
   input  logic [((VALUE_BITS+RADIX_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // packed_value [63:0]
   output logic [RESULT_BITS-1:0]                        rsp_tdata,
   // status [1:0]
   output logic [STATUS_BITS-1:0]                        rsp_tuser
);

   rdp_op_type   cmd;
   rdp_stat_type stat;

   rdp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rdp_dpath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .number     (req_tdata[VALUE_BITS-1:0]),
      .radix      (req_tdata[VALUE_BITS+RADIX_BITS-1:VALUE_BITS]),
      .stat       (stat),
      .out_value  (rsp_tdata),
      .out_status (rsp_tuser)
   );

endmodule
